[sv/rmm_pkg.sv]
// Shared types, constants and helpers for the region mapped memory.
// Used by the decoder, the top level and the port checker; no dependencies.
`default_nettype none

package rmm_pkg;

   localparam int REGION_COUNT = 4;
   localparam int REGION_BYTES = 4096;

   localparam int ADDR_W    = 32;
   localparam int DATA_W    = 32;
   localparam int LEN_W     = 13;
   localparam int SIZE_W    = 2;
   localparam int CSR_IDX_W = 3;

   localparam int REGION_W    = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
   localparam int REL_W       = $clog2(REGION_BYTES + 1);
   localparam int CMP_W       = ((REL_W > LEN_W) ? REL_W : LEN_W) + 1;
   localparam int TOTAL_BYTES = REGION_COUNT * REGION_BYTES;
   localparam int GADDR_W     = $clog2(TOTAL_BYTES);
   localparam int LANES       = 4;
   localparam int ROWS        = (TOTAL_BYTES + LANES - 1) / LANES;
   localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;

   // register map: bases first, lengths after
   localparam logic [CSR_IDX_W-1:0] REG_BASE_A   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH_A = 3'd4;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_UNMAPPED     = 2'd1,
      STATUS_OUT_OF_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OFFSET,
      ST_CHECK,
      ST_ACCESS,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic offset_en;
      logic check_en;
   } dec_ctrl_type;

   typedef struct packed {
      status_type           status;
      logic [GADDR_W-1:0]   gaddr;
   } dec_result_type;

   // byte count of an access; the unused code counts as a word
   function automatic logic [2:0] size_bytes(input logic [SIZE_W-1:0] code);
      logic [2:0] nb;
      case (code)
         SIZE_BYTE: nb = 3'd1;
         SIZE_HALF: nb = 3'd2;
         default:   nb = 3'd4;
      endcase
      return nb;
   endfunction

endpackage

`default_nettype wire

[sv/rmm_lane_ram.sv]
// One byte lane of the bank storage: single port, registered read data.
// Generic; no package dependencies.
`default_nettype none

module rmm_lane_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wr_data,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/rmm_decode.sv]
// Region map registers and the two-stage address decoder.
// Depends on rmm_pkg for widths, status codes and the control and result structs.
`default_nettype none

module rmm_decode
   import rmm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_data,
   input  wire logic [ADDR_W-1:0]    byte_address,
   input  wire logic [SIZE_W-1:0]    size_code,
   input  wire dec_ctrl_type         ctrl,
   output dec_result_type            result
);

   logic [ADDR_W-1:0] base_ff [REGION_COUNT];
   logic [LEN_W-1:0]  len_ff  [REGION_COUNT];

   logic [REL_W-1:0]  rel_ff  [REGION_COUNT];
   logic [REL_W-1:0]  rel_in  [REGION_COUNT];
   logic              cand_ff [REGION_COUNT];
   logic              cand_in [REGION_COUNT];

   dec_result_type    result_ff;
   dec_result_type    result_in;

   // region map registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REGION_COUNT; i++) begin
            base_ff[i] <= '0;
            len_ff[i]  <= '0;
         end
      end else if (csr_wr_en) begin
         for (int i = 0; i < REGION_COUNT; i++) begin
            if (csr_index == REG_BASE_A + CSR_IDX_W'(i)) begin
               base_ff[i] <= csr_data;
            end
            if (csr_index == REG_LENGTH_A + CSR_IDX_W'(i)) begin
               len_ff[i] <= csr_data[LEN_W-1:0];
            end
         end
      end
   end

   // stage one: offset into every region, saturated at the bank size
   always_comb begin
      logic [ADDR_W:0] diff;
      for (int i = 0; i < REGION_COUNT; i++) begin
         diff       = {1'b0, byte_address} - {1'b0, base_ff[i]};
         cand_in[i] = (len_ff[i] != '0) && !diff[ADDR_W];
         rel_in[i]  = (diff[ADDR_W-1:0] >= ADDR_W'(REGION_BYTES)) ?
                      REL_W'(REGION_BYTES) : REL_W'(diff[ADDR_W-1:0]);
      end
   end

   // stage two: greatest base is smallest offset; strict compare keeps lowest index
   always_comb begin
      logic                found;
      logic [REGION_W-1:0] best_idx;
      logic [REL_W-1:0]    best_rel;
      logic [LEN_W-1:0]    best_len;
      logic [CMP_W-1:0]    eff_len;
      logic [CMP_W-1:0]    end_off;
      found    = 1'b0;
      best_idx = '0;
      best_rel = '0;
      best_len = '0;
      for (int i = 0; i < REGION_COUNT; i++) begin
         if (cand_ff[i] && (!found || rel_ff[i] < best_rel)) begin
            found    = 1'b1;
            best_idx = REGION_W'(i);
            best_rel = rel_ff[i];
            best_len = len_ff[i];
         end
      end
      eff_len = (CMP_W'(best_len) > CMP_W'(REGION_BYTES)) ?
                CMP_W'(REGION_BYTES) : CMP_W'(best_len);
      end_off = CMP_W'(best_rel) + CMP_W'(size_bytes(size_code));
      if (!found || CMP_W'(best_rel) >= eff_len) begin
         result_in.status = STATUS_UNMAPPED;
      end else if (end_off > eff_len) begin
         result_in.status = STATUS_OUT_OF_RANGE;
      end else begin
         result_in.status = STATUS_OK;
      end
      result_in.gaddr = GADDR_W'(best_idx) * GADDR_W'(REGION_BYTES) + GADDR_W'(best_rel);
   end

   always_ff @(posedge clock) begin
      if (ctrl.offset_en) begin
         for (int i = 0; i < REGION_COUNT; i++) begin
            rel_ff[i]  <= rel_in[i];
            cand_ff[i] <= cand_in[i];
         end
      end
      if (ctrl.check_en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

[sv/region_mapped_memory.sv]
// Each accepted request runs in turn through the decode (offset and check states),
// bank access and response steps; no new request is taken until its response is
// loaded into the output register, and a stalled response holds the response step.
// Reset: a clearing pass zeroes the banks, one row of four byte lanes per cycle,
// ROWS rows in all (4096 at the default sizes); requests are held off until it ends.
// Depends on rmm_pkg, rmm_decode and rmm_lane_ram.
`default_nettype none

module region_mapped_memory
   import rmm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_opcode,
   input  wire logic [ADDR_W-1:0]    req_byte_address,
   input  wire logic [SIZE_W-1:0]    req_size_code,
   input  wire logic [DATA_W-1:0]    req_write_data,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [DATA_W-1:0]    rsp_read_data,
   output logic      [1:0]           rsp_access_status,

   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_data
);

   state_type            state_ff, state_in;
   logic [ROW_W-1:0]     clear_row_ff, clear_row_in;

   logic                 opcode_ff;
   logic [ADDR_W-1:0]    address_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [DATA_W-1:0]    wdata_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_load;

   dec_ctrl_type         dec_ctrl;
   dec_result_type       dec_result;

   logic                 lane_wr_en   [LANES];
   logic                 lane_rd_en   [LANES];
   logic [ROW_W-1:0]     lane_row     [LANES];
   logic [7:0]           lane_wr_data [LANES];
   logic [7:0]           lane_rd_data [LANES];

   logic                 accept;
   logic [2:0]           nbytes;
   logic [1:0]           lane_off;
   logic [DATA_W-1:0]    gathered;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign nbytes    = size_bytes(size_ff);
   assign lane_off  = dec_result.gaddr[1:0];

   assign dec_ctrl.offset_en = (state_ff == ST_OFFSET);
   assign dec_ctrl.check_en  = (state_ff == ST_CHECK);

   rmm_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .byte_address (address_ff),
      .size_code    (size_ff),
      .ctrl         (dec_ctrl),
      .result       (dec_result)
   );

   // byte k of the access sits in lane (offset + k) mod 4
   always_comb begin
      logic [1:0]       k;
      logic [GADDR_W-1:0] row_base;
      row_base = dec_result.gaddr >> 2;
      for (int j = 0; j < LANES; j++) begin
         k               = 2'(j) - lane_off;
         lane_wr_data[j] = wdata_ff[8*k +: 8];
         lane_row[j]     = ROW_W'(row_base) + ROW_W'(2'(j) < lane_off);
         lane_wr_en[j]   = (state_ff == ST_ACCESS) && (opcode_ff == OP_WRITE) &&
                           (dec_result.status == STATUS_OK) && ({1'b0, k} < nbytes);
         lane_rd_en[j]   = (state_ff == ST_ACCESS) && (opcode_ff == OP_READ);
         if (state_ff == ST_CLEAR) begin
            lane_wr_en[j]   = 1'b1;
            lane_row[j]     = clear_row_ff;
            lane_wr_data[j] = '0;
         end
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      rmm_lane_ram #(
         .DEPTH  (ROWS),
         .ADDR_W (ROW_W),
         .DATA_W (8)
      ) u_ram (
         .clock   (clock),
         .wr_en   (lane_wr_en[g]),
         .rd_en   (lane_rd_en[g]),
         .addr    (lane_row[g]),
         .wr_data (lane_wr_data[g]),
         .rd_data (lane_rd_data[g])
      );
   end

   // rotate lanes back into byte order, drop bytes past the access width
   always_comb begin
      logic [1:0] lane_sel;
      gathered = '0;
      for (int k = 0; k < LANES; k++) begin
         lane_sel = lane_off + 2'(k);
         if (3'(k) < nbytes) begin
            gathered[8*k +: 8] = lane_rd_data[lane_sel];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clear_row_in  = clear_row_ff;
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_row_in = clear_row_ff + 1'b1;
            if (clear_row_ff == ROW_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_OFFSET;
            end
         end
         ST_OFFSET: state_in = ST_CHECK;
         ST_CHECK:  state_in = ST_ACCESS;
         ST_ACCESS: state_in = ST_RESP;
         ST_RESP: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = dec_result.status;
               rsp_data_in   = ((opcode_ff == OP_READ) && (dec_result.status == STATUS_OK)) ?
                               gathered : '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_row_ff <= clear_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff  <= req_opcode;
         address_ff <= req_byte_address;
         size_ff    <= req_size_code;
         wdata_ff   <= req_write_data;
      end
      if (rsp_load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_access_status = rsp_status_ff;

endmodule

`default_nettype wire

[sv/rmm_checker.sv]
// Port-level checks for region_mapped_memory, attached by the bind below.
// Depends on rmm_pkg for widths and status codes.
`default_nettype none

module rmm_checker
   import rmm_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [DATA_W-1:0] rsp_read_data,
   input wire logic [1:0]        rsp_access_status
);

   // no request is taken while the banks are being cleared
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request ready during bank clear");

   // one request in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request accepted while one is in flight");

   // failed accesses return zero data
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_access_status != STATUS_OK) |-> (rsp_read_data == '0))
      else $error("nonzero read data on failed access");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data) &&
                                     $stable(rsp_access_status)))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_access_status != 2'd3))
      else $error("undefined response status");

endmodule

bind region_mapped_memory rmm_checker u_rmm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_read_data     (rsp_read_data),
   .rsp_access_status (rsp_access_status)
);

`default_nettype wire

[test/tb_region_mapped_memory.sv]
// Self-checking bench for region_mapped_memory: directed and random loads and stores
// checked against a behavioral copy of the region map and the per-region byte banks.
// Depends on rmm_pkg and the region_mapped_memory RTL.
`default_nettype none

module tb_region_mapped_memory;
   timeunit 1ns;
   timeprecision 1ps;
   import rmm_pkg::*;

   localparam logic [SIZE_W-1:0] SIZE_WORD  = 2'd2;
   localparam logic [SIZE_W-1:0] SIZE_SPARE = 2'd3;
   // reset clearing pass plus the longest response stall, with a wide margin
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int FLUSH_CYCLES   = 8;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 250;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      status_type        status;
   } access_result_type;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic                 req_opcode       = OP_READ;
   logic [ADDR_W-1:0]    req_byte_address = '0;
   logic [SIZE_W-1:0]    req_size_code    = SIZE_BYTE;
   logic [DATA_W-1:0]    req_write_data   = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [DATA_W-1:0]    rsp_read_data;
   logic [1:0]           rsp_access_status;
   logic                 csr_wr_en        = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [DATA_W-1:0]    csr_data         = '0;

   // mirror of the block's map and banks
   logic [ADDR_W-1:0] map_base   [REGION_COUNT];
   logic [LEN_W-1:0]  map_length [REGION_COUNT];
   logic [7:0]        bank_bytes [REGION_COUNT*REGION_BYTES];

   access_result_type access_results_due [$];

   int error_count     = 0;
   int items_sent      = 0;
   int responses_seen  = 0;
   int maps_loaded     = 0;
   int status_ok       = 0;
   int status_unmapped = 0;
   int status_overrun  = 0;
   int idle_cycles     = 0;
   int rsp_stall_left  = 0;
   bit steady_flow     = 1'b0;

   region_mapped_memory u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_byte_address  (req_byte_address),
      .req_size_code     (req_size_code),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_access_status (rsp_access_status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // start low so the first rising edge falls after time zero
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      for (int i = 0; i < REGION_COUNT*REGION_BYTES; i++) bank_bytes[i] = 8'h00;
      for (int i = 0; i < REGION_COUNT; i++) begin
         map_base[i]   = '0;
         map_length[i] = '0;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [LEN_W-1:0] random_length();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return LEN_W'($urandom_range(1, 4));
         2:       return LEN_W'(REGION_BYTES);
         3:       return LEN_W'($urandom_range(REGION_BYTES + 1, 8191));
         default: return LEN_W'($urandom_range(16, 300));
      endcase
   endfunction

   // decode one access against the mirrored map; stores update the banks
   function automatic access_result_type mem_access(input logic op,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [SIZE_W-1:0] code,
                                                    input logic [DATA_W-1:0] wdata);
      int hit, k, nbytes, start;
      logic [ADDR_W:0] rel, lim;
      access_result_type res;
      hit = -1;
      for (k = 0; k < REGION_COUNT; k++)
         if (map_length[k] != 0 && map_base[k] <= addr &&
             (hit < 0 || map_base[k] > map_base[hit]))
            hit = k;
      res.read_data = '0;
      res.status    = STATUS_OK;
      nbytes = (code == SIZE_BYTE) ? 1 : (code == SIZE_HALF) ? 2 : 4;
      if (hit < 0) begin
         res.status = STATUS_UNMAPPED;
      end else begin
         rel = {1'b0, addr} - {1'b0, map_base[hit]};
         lim = (map_length[hit] > REGION_BYTES) ? (ADDR_W+1)'(REGION_BYTES)
                                                : (ADDR_W+1)'(map_length[hit]);
         if (rel >= lim) begin
            res.status = STATUS_UNMAPPED;
         end else if (rel + (ADDR_W+1)'(nbytes) > lim) begin
            res.status = STATUS_OUT_OF_RANGE;
         end else begin
            start = hit * REGION_BYTES + int'(rel);
            for (k = 0; k < nbytes; k++)
               if (op == OP_WRITE) bank_bytes[start + k] = wdata[8*k +: 8];
               else res.read_data[8*k +: 8] = bank_bytes[start + k];
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("%0t ns: %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr,
                              input logic [SIZE_W-1:0] code,
                              input logic [DATA_W-1:0] wdata);
      int gap;
      gap = steady_flow ? 0 : idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_byte_address <= addr;
      req_size_code    <= code;
      req_write_data   <= wdata;
      do @(posedge clock); while (!req_ready);
      access_results_due.push_back(mem_access(op, addr, code, wdata));
      items_sent++;
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (access_results_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_region(input int k, input logic [ADDR_W-1:0] base,
                             input logic [LEN_W-1:0] len);
      map_base[k]   = base;
      map_length[k] = len;
   endtask

   // write every base and length register from the mirror, one per cycle
   task automatic apply_region_map();
      for (int k = 0; k < REGION_COUNT; k++) begin
         csr_wr_en <= 1'b1;
         csr_index <= REG_BASE_A + CSR_IDX_W'(k);
         csr_data  <= map_base[k];
         @(posedge clock);
         csr_index <= REG_LENGTH_A + CSR_IDX_W'(k);
         csr_data  <= DATA_W'(map_length[k]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      maps_loaded++;
   endtask

   task automatic build_random_map(input int kind);
      logic [ADDR_W-1:0] anchor, base;
      logic [LEN_W-1:0] len;
      anchor = $urandom;
      for (int k = 0; k < REGION_COUNT; k++) begin
         case (kind)
            0: set_region(k, anchor + ADDR_W'($urandom_range(0, 3)) * 32'h400, random_length());
            1: set_region(k, $urandom, random_length());
            2: begin
               case ($urandom_range(0, 3))
                  0:       base = 32'h0000_0000;
                  1:       base = 32'hFFFF_FFFF;
                  2:       base = 32'hFFFF_F000;
                  default: base = 32'h8000_0000;
               endcase
               case ($urandom_range(0, 2))
                  0:       len = LEN_W'(1);
                  1:       len = LEN_W'(REGION_BYTES);
                  default: len = LEN_W'(8191);
               endcase
               set_region(k, base, len);
            end
            // bases drawn from two values, so ties go to the lowest index
            default: set_region(k, anchor + ($urandom_range(0, 1) ? 32'h0 : 32'h10),
                                random_length());
         endcase
      end
   endtask

   // mostly accesses aimed at a region's start, end and just past it
   task automatic random_accesses(input int count);
      int k, lim, pick;
      logic [ADDR_W-1:0] addr;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 149) == 0) wait_for_responses();
         k    = $urandom_range(0, REGION_COUNT - 1);
         lim  = (map_length[k] > REGION_BYTES) ? REGION_BYTES : int'(map_length[k]);
         pick = $urandom_range(0, 99);
         if (pick < 15) addr = $urandom;
         else if (lim == 0) addr = map_base[k] + $urandom_range(0, 7);
         else if (pick < 55) addr = map_base[k] + $urandom_range(0, (lim > 32) ? 31 : lim - 1);
         else if (pick < 75) addr = map_base[k] + lim - $urandom_range(1, (lim > 4) ? 4 : lim);
         else if (pick < 85) addr = map_base[k] + $urandom_range(0, lim - 1);
         else if (pick < 93) addr = map_base[k] + lim + $urandom_range(0, 3);
         else addr = map_base[k] - $urandom_range(1, 8);
         send_access(logic'($urandom_range(0, 1)), addr, SIZE_W'($urandom_range(0, 3)),
                     $urandom);
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_reset_map();
      send_access(OP_READ, 32'h0000_0000, SIZE_WORD, $urandom);
      send_access(OP_WRITE, 32'hFFFF_FFFF, SIZE_BYTE, 32'hFFFF_FFFF);
      wait_for_responses();
   endtask

   // region one ties region zero, region two is saturated, region three tops the space
   task automatic test_decode_edges();
      set_region(0, 32'h0000_1000, 13'd4096);
      set_region(1, 32'h0000_1000, 13'd100);
      set_region(2, 32'h8000_0000, 13'd8191);
      set_region(3, 32'hFFFF_F000, 13'd4096);
      apply_region_map();
      send_access(OP_READ,  32'h0000_0FFF, SIZE_BYTE, $urandom);
      send_access(OP_WRITE, 32'h0000_1000, SIZE_WORD, 32'hA5A5_5A5A);
      send_access(OP_READ,  32'h0000_1001, SIZE_BYTE, $urandom);
      send_access(OP_READ,  32'h0000_1002, SIZE_HALF, $urandom);
      send_access(OP_WRITE, 32'h0000_1FFF, SIZE_BYTE, 32'hFFFF_FFFF);
      send_access(OP_WRITE, 32'h0000_1FFF, SIZE_HALF, 32'h0000_0000);
      send_access(OP_READ,  32'h0000_1FFD, SIZE_WORD, $urandom);
      send_access(OP_READ,  32'h0000_2000, SIZE_BYTE, $urandom);
      send_access(OP_WRITE, 32'h8000_0FFC, SIZE_SPARE, 32'h1234_5678);
      send_access(OP_READ,  32'h8000_0FFC, SIZE_WORD, $urandom);
      send_access(OP_READ,  32'h8000_1000, SIZE_BYTE, $urandom);
      send_access(OP_WRITE, 32'hFFFF_FFFC, SIZE_WORD, 32'hDEAD_BEEF);
      send_access(OP_READ,  32'hFFFF_FFFF, SIZE_HALF, $urandom);
      send_access(OP_READ,  32'hFFFF_FFFF, SIZE_BYTE, $urandom);
      wait_for_responses();
   endtask

   // the picked region decides even when a lower region covers the address
   task automatic test_overlap_and_disable();
      set_region(0, 32'h0000_1000, 13'd0);
      set_region(1, 32'h0000_0800, 13'd16);
      set_region(2, 32'h0000_0000, 13'd4096);
      set_region(3, 32'hFFFF_FFFF, 13'd1);
      apply_region_map();
      send_access(OP_READ,  32'h0000_0900, SIZE_BYTE, $urandom);
      send_access(OP_READ,  32'h0000_1000, SIZE_WORD, $urandom);
      send_access(OP_READ,  32'h0000_0800, SIZE_WORD, $urandom);
      send_access(OP_WRITE, 32'h0000_0000, SIZE_BYTE, 32'h0000_00C3);
      send_access(OP_READ,  32'h0000_0000, SIZE_HALF, $urandom);
      send_access(OP_WRITE, 32'hFFFF_FFFF, SIZE_WORD, 32'h0102_0304);
      send_access(OP_READ,  32'hFFFF_FFFF, SIZE_BYTE, $urandom);
      wait_for_responses();
   endtask

   // map changes must leave the banks alone
   task automatic test_retained_banks();
      set_region(0, 32'h0000_1000, 13'd4096);
      set_region(1, 32'h0000_1000, 13'd100);
      set_region(2, 32'h8000_0000, 13'd8191);
      set_region(3, 32'hFFFF_F000, 13'd4096);
      apply_region_map();
      send_access(OP_READ, 32'h0000_1000, SIZE_WORD, $urandom);
      send_access(OP_READ, 32'hFFFF_FFFC, SIZE_WORD, $urandom);
      send_access(OP_READ, 32'h8000_0FFC, SIZE_SPARE, $urandom);
      wait_for_responses();
   endtask

   task automatic test_random_maps();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         build_random_map(p % 4);
         apply_region_map();
         random_accesses(PHASE_ITEMS);
         wait_for_responses();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_map();
      test_decode_edges();
      test_overlap_and_disable();
      test_retained_banks();
      test_random_maps();
      wait_for_responses();
      repeat (FLUSH_CYCLES) @(posedge clock);
      $display("Sent %0d requests over %0d region maps and checked %0d responses.",
               items_sent, maps_loaded, responses_seen);
      $display("Responses by status: %0d ok, %0d unmapped, %0d past region end.",
               status_ok, status_unmapped, status_overrun);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!steady_flow) rsp_stall_left <= idle_length();
      end
   end

   always @(posedge clock) begin : check_responses
      access_result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         case (rsp_access_status)
            STATUS_OK:       status_ok++;
            STATUS_UNMAPPED: status_unmapped++;
            default:         status_overrun++;
         endcase
         if (access_results_due.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_read_data, '0);
         end else begin
            due = access_results_due.pop_front();
            if (rsp_read_data !== due.read_data)
               report_mismatch("read data", rsp_read_data, due.read_data);
            if (rsp_access_status !== due.status)
               report_mismatch("access status", DATA_W'(rsp_access_status),
                               DATA_W'(due.status));
         end
      end
   end

   // end the run if neither channel moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

`default_nettype wire
